// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, sampled on clk, off during rst
`define CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, sampled on clk, off during rst
`define CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: src/chcc_pkg.sv
package chcc_pkg;

  localparam int CELLS_DEF    = 1024;
  localparam int ROOTS_DEF    = 7;
  localparam int TAG_BITS_DEF = 3;

  localparam int OBJ_W  = 32;
  localparam int HC_W   = 11;
  localparam int RI_W   = 3;
  localparam logic [HC_W-1:0] HC_RESET = 11'd1024;

  localparam int TAG_PAIR  = 0;
  localparam int TAG_HEART = 1;
  localparam int TAG_NULL  = 4;

  typedef enum logic [2:0] {
    OP_CONS, OP_CAR, OP_CDR, OP_SET_CAR, OP_SET_CDR, OP_WRITE_ROOT, OP_READ_ROOT, OP_COLLECT
  } op_t;

  typedef enum logic [1:0] {
    ST_OK, ST_NOT_PAIR, ST_NO_MEM
  } stat_t;

  typedef enum logic [4:0] {
    ACT_NONE, ACT_LATCH, ACT_ALLOC, ACT_FULL, ACT_BAD_PAIR, ACT_ACC_RD, ACT_ACC_RES,
    ACT_SET, ACT_WROOT, ACT_RROOT, ACT_FLIP, ACT_CLR_INIT, ACT_CLR, ACT_RT_LOAD,
    ACT_OPA_LOAD, ACT_OPB_LOAD, ACT_RL_CHK, ACT_RL_RD, ACT_RL_MARK, ACT_SC_CHK,
    ACT_SC_RD, ACT_TMPB_LOAD, ACT_SC_WR, ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    TGT_ROOT, TGT_OPA, TGT_OPB, TGT_TMPA, TGT_TMPB
  } tgt_t;

  typedef struct packed {
    act_t act;
    tgt_t tgt;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic a_valid;
    logic obj_valid;
    logic fwd;
    logic full;
    logic clr_last;
    logic rt_done;
    logic scan_more;
    logic out_free;
  } sts_t;

endpackage

// File: src/chcc_ctrl.sv
module chcc_ctrl import chcc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_ACC, S_ALLOC, S_CLR, S_RT, S_OPA, S_OPB, S_RL_CHK, S_RL_RD,
    S_RL_MARK, S_SC_CHK, S_SC_RD, S_TMPB, S_SC_WR, S_FIN
  } state_t;

  state_t state, state_next;
  tgt_t   tgt, tgt_next;
  logic   extra, extra_next;
  logic   collected, collected_next;

  function automatic state_t after_reloc(tgt_t t);
    case (t)
      TGT_ROOT: after_reloc = S_RT;
      TGT_OPA:  after_reloc = S_OPB;
      TGT_OPB:  after_reloc = S_SC_CHK;
      TGT_TMPA: after_reloc = S_TMPB;
      TGT_TMPB: after_reloc = S_SC_WR;
      default:  after_reloc = S_SC_CHK;
    endcase
  endfunction

  assign item_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next     = state;
    tgt_next       = tgt;
    extra_next     = extra;
    collected_next = collected;
    cmd.act        = ACT_NONE;
    cmd.tgt        = tgt;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.act    = ACT_LATCH;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_CONS: begin
            collected_next = 1'b0;
            state_next     = S_ALLOC;
          end
          OP_CAR, OP_CDR: begin
            cmd.act    = sts.a_valid ? ACT_ACC_RD : ACT_BAD_PAIR;
            state_next = sts.a_valid ? S_ACC : S_FIN;
          end
          OP_SET_CAR, OP_SET_CDR: begin
            cmd.act    = sts.a_valid ? ACT_SET : ACT_BAD_PAIR;
            state_next = S_FIN;
          end
          OP_WRITE_ROOT: begin
            cmd.act    = ACT_WROOT;
            state_next = S_FIN;
          end
          OP_READ_ROOT: begin
            cmd.act    = ACT_RROOT;
            state_next = S_FIN;
          end
          default: begin
            cmd.act    = ACT_CLR_INIT;
            extra_next = 1'b0;
            state_next = S_CLR;
          end
        endcase
      end
      S_ACC: begin
        cmd.act    = ACT_ACC_RES;
        state_next = S_FIN;
      end
      S_ALLOC: begin
        if (!sts.full) begin
          cmd.act    = ACT_ALLOC;
          state_next = S_FIN;
        end else if (!collected) begin
          cmd.act        = ACT_CLR_INIT;
          extra_next     = 1'b1;
          collected_next = 1'b1;
          state_next     = S_CLR;
        end else begin
          cmd.act    = ACT_FULL;
          state_next = S_FIN;
        end
      end
      S_CLR: begin
        cmd.act = ACT_CLR;
        if (sts.clr_last) state_next = S_RT;
      end
      S_RT: begin
        if (sts.rt_done) begin
          state_next = extra ? S_OPA : S_SC_CHK;
        end else begin
          cmd.act    = ACT_RT_LOAD;
          tgt_next   = TGT_ROOT;
          state_next = S_RL_CHK;
        end
      end
      S_OPA: begin
        cmd.act    = ACT_OPA_LOAD;
        tgt_next   = TGT_OPA;
        state_next = S_RL_CHK;
      end
      S_OPB: begin
        cmd.act    = ACT_OPB_LOAD;
        tgt_next   = TGT_OPB;
        state_next = S_RL_CHK;
      end
      S_RL_CHK: begin
        cmd.act    = ACT_RL_CHK;
        state_next = sts.obj_valid ? S_RL_RD : after_reloc(tgt);
      end
      S_RL_RD: begin
        cmd.act    = ACT_RL_RD;
        state_next = sts.fwd ? after_reloc(tgt) : S_RL_MARK;
      end
      S_RL_MARK: begin
        cmd.act    = ACT_RL_MARK;
        state_next = after_reloc(tgt);
      end
      S_SC_CHK: begin
        if (sts.scan_more) begin
          cmd.act    = ACT_SC_CHK;
          state_next = S_SC_RD;
        end else begin
          cmd.act    = ACT_FLIP;
          state_next = extra ? S_ALLOC : S_FIN;
        end
      end
      S_SC_RD: begin
        cmd.act    = ACT_SC_RD;
        tgt_next   = TGT_TMPA;
        state_next = S_RL_CHK;
      end
      S_TMPB: begin
        cmd.act    = ACT_TMPB_LOAD;
        tgt_next   = TGT_TMPB;
        state_next = S_RL_CHK;
      end
      S_SC_WR: begin
        cmd.act    = ACT_SC_WR;
        state_next = S_SC_CHK;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.act    = ACT_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tgt       <= TGT_ROOT;
      extra     <= 1'b0;
      collected <= 1'b0;
    end else begin
      state     <= state_next;
      tgt       <= tgt_next;
      extra     <= extra_next;
      collected <= collected_next;
    end
  end

endmodule

// File: src/chcc_dp.sv
module chcc_dp import chcc_pkg::*; #(
  parameter int CELLS    = CELLS_DEF,
  parameter int ROOTS    = ROOTS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        opcode,
  input  logic [OBJ_W-1:0]  object_a,
  input  logic [OBJ_W-1:0]  object_b,
  input  logic [RI_W-1:0]   root_index,
  input  logic              heap_cells_we,
  input  logic [HC_W-1:0]   heap_cells_data,
  input  logic              result_ready,
  output logic              result_valid,
  output logic [OBJ_W-1:0]  result_object,
  output logic [1:0]        status,
  output logic [HC_W-1:0]   cells_in_use,
  input  cmd_t              cmd,
  output sts_t              sts
);

  localparam int VBITS = OBJ_W - TAG_BITS;
  localparam int IW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int AW    = $clog2(2 * CELLS);
  localparam int RW    = (ROOTS > 1) ? $clog2(ROOTS) : 1;
  localparam int NW    = $clog2(ROOTS + 1);

  logic [OBJ_W-1:0] car_mem [2*CELLS];
  logic [OBJ_W-1:0] cdr_mem [2*CELLS];
  logic             fwd_mem [CELLS];

  op_t              op_q;
  logic [OBJ_W-1:0] a_q, b_q, obj_q, tmpa, tmpb, car_q, cdr_q, res_q;
  logic [RI_W-1:0]  ri_q;
  stat_t            stat_q;
  logic             fwd_q;
  logic [HC_W-1:0]  hc;
  logic             half;
  logic [CW-1:0]    free_q, scan_q, limit;
  logic [IW-1:0]    clr_q;
  logic [NW-1:0]    cnt_q;
  logic [OBJ_W-1:0] roots [ROOTS];

  logic             car_we, cdr_we, fwd_we, rd_en;
  logic [AW-1:0]    car_wa, cdr_wa, rd_a;
  logic [OBJ_W-1:0] car_wd, cdr_wd;
  logic [IW-1:0]    fwd_wa;
  logic             fwd_wd;
  logic             st_en;
  logic [OBJ_W-1:0] rv, free_obj;
  logic             ri_ok, a_valid, obj_valid, out_free;
  logic [RW-1:0]    ri_idx, cnt_idx;
  logic [IW-1:0]    a_idx, obj_idx, free_idx, scan_idx;

  function automatic logic [AW-1:0] addr(input logic h, input logic [IW-1:0] idx);
    addr = h ? (AW'(CELLS) + AW'(idx)) : AW'(idx);
  endfunction

  always_comb begin
    if (hc == '0) limit = CW'(1);
    else if (32'(hc) > CELLS) limit = CW'(CELLS);
    else limit = CW'(hc);
  end

  assign a_valid   = (a_q[OBJ_W-1 -: TAG_BITS] == TAG_BITS'(TAG_PAIR))
                     && (a_q[VBITS-1:0] < VBITS'(limit));
  assign obj_valid = (obj_q[OBJ_W-1 -: TAG_BITS] == TAG_BITS'(TAG_PAIR))
                     && (obj_q[VBITS-1:0] < VBITS'(limit));
  assign a_idx     = a_q[IW-1:0];
  assign obj_idx   = obj_q[IW-1:0];
  assign free_idx  = free_q[IW-1:0];
  assign scan_idx  = scan_q[IW-1:0];
  assign free_obj  = {TAG_BITS'(TAG_PAIR), VBITS'(free_q)};
  assign ri_ok     = 32'(ri_q) < ROOTS;
  assign ri_idx    = RW'(ri_q);
  assign cnt_idx   = cnt_q[RW-1:0];
  assign out_free  = !result_valid || result_ready;

  always_comb begin
    car_we = 1'b0;
    cdr_we = 1'b0;
    fwd_we = 1'b0;
    rd_en  = 1'b0;
    car_wa = addr(half, free_idx);
    cdr_wa = addr(half, free_idx);
    car_wd = a_q;
    cdr_wd = b_q;
    rd_a   = addr(half, a_idx);
    fwd_wa = obj_idx;
    fwd_wd = 1'b1;
    st_en  = 1'b0;
    rv     = obj_q;
    case (cmd.act)
      ACT_ALLOC: begin
        car_we = 1'b1;
        cdr_we = 1'b1;
      end
      ACT_SET: begin
        car_we = (op_q == OP_SET_CAR);
        cdr_we = (op_q != OP_SET_CAR);
        car_wa = addr(half, a_idx);
        cdr_wa = addr(half, a_idx);
        car_wd = b_q;
      end
      ACT_ACC_RD: rd_en = 1'b1;
      ACT_RL_CHK: begin
        rd_en = obj_valid;
        rd_a  = addr(half, obj_idx);
        st_en = !obj_valid;
      end
      ACT_RL_RD: begin
        car_we = !fwd_q;
        cdr_we = !fwd_q;
        car_wa = addr(!half, free_idx);
        cdr_wa = addr(!half, free_idx);
        car_wd = car_q;
        cdr_wd = cdr_q;
        st_en  = fwd_q;
        rv     = {TAG_BITS'(TAG_PAIR), cdr_q[VBITS-1:0]};
      end
      ACT_RL_MARK: begin
        car_we = 1'b1;
        cdr_we = 1'b1;
        fwd_we = 1'b1;
        car_wa = addr(half, obj_idx);
        cdr_wa = addr(half, obj_idx);
        car_wd = {TAG_BITS'(TAG_HEART), car_q[VBITS-1:0]};
        cdr_wd = free_obj;
        st_en  = 1'b1;
        rv     = free_obj;
      end
      ACT_CLR: begin
        fwd_we = 1'b1;
        fwd_wa = clr_q;
        fwd_wd = 1'b0;
      end
      ACT_SC_CHK: begin
        rd_en = 1'b1;
        rd_a  = addr(!half, scan_idx);
      end
      ACT_SC_WR: begin
        car_we = 1'b1;
        cdr_we = 1'b1;
        car_wa = addr(!half, scan_idx);
        cdr_wa = addr(!half, scan_idx);
        car_wd = tmpa;
        cdr_wd = tmpb;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (car_we) car_mem[car_wa] <= car_wd;
    if (cdr_we) cdr_mem[cdr_wa] <= cdr_wd;
    if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
    if (rd_en) begin
      car_q <= car_mem[rd_a];
      cdr_q <= cdr_mem[rd_a];
      fwd_q <= fwd_mem[obj_idx];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_LATCH: begin
        op_q <= op_t'(opcode);
        a_q  <= object_a;
        b_q  <= object_b;
        ri_q <= root_index;
      end
      ACT_ALLOC: begin
        res_q  <= free_obj;
        stat_q <= ST_OK;
      end
      ACT_FULL: begin
        res_q  <= '0;
        stat_q <= ST_NO_MEM;
      end
      ACT_BAD_PAIR: begin
        res_q  <= '0;
        stat_q <= ST_NOT_PAIR;
      end
      ACT_ACC_RES: begin
        res_q  <= (op_q == OP_CAR) ? car_q : cdr_q;
        stat_q <= ST_OK;
      end
      ACT_SET, ACT_WROOT, ACT_FLIP: begin
        res_q  <= '0;
        stat_q <= ST_OK;
      end
      ACT_RROOT: begin
        res_q  <= ri_ok ? roots[ri_idx] : '0;
        stat_q <= ST_OK;
      end
      ACT_CLR_INIT: clr_q <= '0;
      ACT_CLR:      clr_q <= clr_q + IW'(1);
      ACT_RT_LOAD:  obj_q <= roots[cnt_idx];
      ACT_OPA_LOAD: obj_q <= a_q;
      ACT_OPB_LOAD: obj_q <= b_q;
      ACT_SC_RD: begin
        tmpa  <= car_q;
        tmpb  <= cdr_q;
        obj_q <= car_q;
      end
      ACT_TMPB_LOAD: obj_q <= tmpb;
      default: ;
    endcase
    if (st_en) begin
      case (cmd.tgt)
        TGT_OPA:  a_q  <= rv;
        TGT_OPB:  b_q  <= rv;
        TGT_TMPA: tmpa <= rv;
        TGT_TMPB: tmpb <= rv;
        default: ;
      endcase
    end
    if (cmd.act == ACT_EMIT) begin
      result_object <= res_q;
      status        <= stat_q;
      cells_in_use  <= HC_W'(free_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hc           <= HC_RESET;
      half         <= 1'b0;
      free_q       <= '0;
      scan_q       <= '0;
      cnt_q        <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < ROOTS; i++) roots[i] <= {TAG_BITS'(TAG_NULL), VBITS'(0)};
    end else begin
      if (heap_cells_we) hc <= heap_cells_data;
      if (cmd.act == ACT_EMIT) result_valid <= 1'b1;
      else if (result_valid && result_ready) result_valid <= 1'b0;
      case (cmd.act)
        ACT_ALLOC, ACT_RL_MARK: free_q <= free_q + CW'(1);
        ACT_WROOT: if (ri_ok) roots[ri_idx] <= b_q;
        ACT_FLIP:  half <= !half;
        ACT_CLR_INIT: begin
          free_q <= '0;
          scan_q <= '0;
          cnt_q  <= '0;
        end
        ACT_SC_WR: scan_q <= scan_q + CW'(1);
        default: ;
      endcase
      if (st_en && cmd.tgt == TGT_ROOT) begin
        roots[cnt_idx] <= rv;
        cnt_q          <= cnt_q + NW'(1);
      end
    end
  end

  assign sts.op        = op_q;
  assign sts.a_valid   = a_valid;
  assign sts.obj_valid = obj_valid;
  assign sts.fwd       = fwd_q;
  assign sts.full      = (free_q >= limit);
  assign sts.clr_last  = (32'(clr_q) == 32'(limit) - 1);
  assign sts.rt_done   = (cnt_q == NW'(ROOTS));
  assign sts.scan_more = (scan_q < free_q);
  assign sts.out_free  = out_free;

endmodule

// File: src/cons_heap_with_copying_collector_unit.sv
// Pair heap of two semispaces with a stop-and-copy collector. One word in,
// one word out per operation. car and cdr pass a registered cell read, and
// cons an allocation step, before the result is raised; the next word is
// taken from the cycle the result is raised. A collection (collect, or cons
// on a full heap) first clears the forwarding marks, one cell per cycle over
// the heap_cells limit, then relocates each root (and for cons both
// operands), and then scans every copied cell, relocating its car and cdr
// and writing it back. Input is held off for the whole operation; a
// finished word waits in the output register while the next word is taken.
module cons_heap_with_copying_collector_unit import chcc_pkg::*; #(
  parameter int CELLS    = CELLS_DEF,
  parameter int ROOTS    = ROOTS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [2:0]        opcode,
  input  logic [OBJ_W-1:0]  object_a,
  input  logic [OBJ_W-1:0]  object_b,
  input  logic [RI_W-1:0]   root_index,
  input  logic              heap_cells_we,
  input  logic [HC_W-1:0]   heap_cells_data,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [OBJ_W-1:0]  result_object,
  output logic [1:0]        status,
  output logic [HC_W-1:0]   cells_in_use
);

  cmd_t cmd;
  sts_t sts;

  chcc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  chcc_dp #(
    .CELLS    (CELLS),
    .ROOTS    (ROOTS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .opcode          (opcode),
    .object_a        (object_a),
    .object_b        (object_b),
    .root_index      (root_index),
    .heap_cells_we   (heap_cells_we),
    .heap_cells_data (heap_cells_data),
    .result_ready    (result_ready),
    .result_valid    (result_valid),
    .result_object   (result_object),
    .status          (status),
    .cells_in_use    (cells_in_use),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// File: src/chcc_checker.sv
`include "assert_macros.svh"

module chcc_checker import chcc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] result_object,
  input logic [1:0]  status
);

  `CHK_IMP(a_status_code, result_valid, status <= ST_NO_MEM, "undefined status code")
  `CHK_IMP(a_error_zero, result_valid && status != ST_OK, result_object == 32'd0,
           "error word carries nonzero result")
  `CHK_NXT(a_one_at_a_time, item_valid && item_ready, !item_ready,
           "new word taken while one is in work")
  `CHK_NXT(a_out_hold, result_valid && !result_ready,
           result_valid && $stable(result_object), "stalled result changed")

endmodule

bind cons_heap_with_copying_collector_unit chcc_checker u_chk (.*);

// File: test/cons_heap_with_copying_collector_unit_tb.sv
`timescale 1ns / 100ps

module cons_heap_with_copying_collector_unit_tb;
  import chcc_pkg::*;

  localparam int NCELL = CELLS_DEF;
  localparam int NROOT = ROOTS_DEF;
  localparam int RUN_LIMIT = 4000000;
  localparam logic [31:0] NULL_WORD = 32'(TAG_NULL) << 29;

  typedef struct {
    op_t          op;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [2:0]   ri;
  } heap_op_t;

  typedef struct {
    logic [31:0]      obj;
    stat_t            st;
    logic [HC_W-1:0]  used;
  } heap_res_t;

  logic              clk = 0;
  logic              rst = 1;
  logic              item_valid = 0;
  logic              item_ready;
  logic [2:0]        opcode = '0;
  logic [31:0]       object_a = '0;
  logic [31:0]       object_b = '0;
  logic [2:0]        root_index = '0;
  logic              heap_cells_we = 0;
  logic [HC_W-1:0]   heap_cells_data = '0;
  logic              result_valid;
  logic              result_ready = 0;
  logic [31:0]       result_object;
  logic [1:0]        status;
  logic [HC_W-1:0]   cells_in_use;

  cons_heap_with_copying_collector_unit i_dut (
    .clk, .rst, .item_valid, .item_ready, .opcode, .object_a, .object_b, .root_index,
    .heap_cells_we, .heap_cells_data, .result_valid, .result_ready, .result_object,
    .status, .cells_in_use
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // heap shadow
  logic [31:0]      car_mem [2*NCELL];
  logic [31:0]      cdr_mem [2*NCELL];
  bit               moved [NCELL];
  bit               half;
  int               alloc_pt;
  int               scan_pt;
  logic [31:0]      roots [NROOT];
  logic [HC_W-1:0]  limit_reg;

  heap_op_t   pending_ops [$];
  heap_res_t  awaited [$];
  int errors = 0;
  int cycles = 0;
  int n_words = 0, n_gc = 0, n_oom = 0, n_bad = 0;
  bit hold_rx = 0;

  function automatic int usable_cells();
    if (limit_reg < 1) return 1;
    if (limit_reg > NCELL) return NCELL;
    return int'(limit_reg);
  endfunction

  function automatic bit is_pair(logic [31:0] obj);
    return obj[31:29] == TAG_PAIR && int'(obj[28:0]) < usable_cells();
  endfunction

  function automatic logic [31:0] forward(logic [31:0] obj, int from, int to);
    int idx;
    if (!is_pair(obj)) return obj;
    idx = int'(obj[28:0]);
    if (!moved[idx]) begin
      car_mem[to + alloc_pt] = car_mem[from + idx];
      cdr_mem[to + alloc_pt] = cdr_mem[from + idx];
      car_mem[from + idx] = {3'(TAG_HEART), car_mem[from + idx][28:0]};
      cdr_mem[from + idx] = {3'b0, 29'(alloc_pt)};
      moved[idx] = 1;
      alloc_pt++;
    end
    return {3'b0, cdr_mem[from + idx][28:0]};
  endfunction

  function automatic void gc(inout logic [31:0] xa, inout logic [31:0] xb, input bit with_ops);
    int from, to;
    from = half ? NCELL : 0;
    to = half ? 0 : NCELL;
    foreach (moved[i]) moved[i] = 0;
    alloc_pt = 0;
    scan_pt = 0;
    for (int i = 0; i < NROOT; i++) roots[i] = forward(roots[i], from, to);
    if (with_ops) begin
      xa = forward(xa, from, to);
      xb = forward(xb, from, to);
    end
    while (scan_pt < alloc_pt) begin
      car_mem[to + scan_pt] = forward(car_mem[to + scan_pt], from, to);
      cdr_mem[to + scan_pt] = forward(cdr_mem[to + scan_pt], from, to);
      scan_pt++;
    end
    half = !half;
    n_gc++;
  endfunction

  function automatic heap_res_t apply_op(heap_op_t w);
    heap_res_t r;
    logic [31:0] xa, xb;
    int base, idx;
    r.obj = '0;
    r.st = ST_OK;
    base = half ? NCELL : 0;
    idx = int'(w.a[28:0]);
    xa = w.a;
    xb = w.b;
    case (w.op)
      OP_CONS: begin
        if (alloc_pt >= usable_cells()) begin
          gc(xa, xb, 1);
          base = half ? NCELL : 0;
        end
        if (alloc_pt >= usable_cells()) begin
          r.st = ST_NO_MEM;
          n_oom++;
        end else begin
          car_mem[base + alloc_pt] = xa;
          cdr_mem[base + alloc_pt] = xb;
          r.obj = 32'(alloc_pt);
          alloc_pt++;
        end
      end
      OP_CAR, OP_CDR, OP_SET_CAR, OP_SET_CDR: begin
        if (!is_pair(w.a)) begin
          r.st = ST_NOT_PAIR;
          n_bad++;
        end else if (w.op == OP_CAR) r.obj = car_mem[base + idx];
        else if (w.op == OP_CDR) r.obj = cdr_mem[base + idx];
        else if (w.op == OP_SET_CAR) car_mem[base + idx] = w.b;
        else cdr_mem[base + idx] = w.b;
      end
      OP_WRITE_ROOT: if (w.ri < NROOT) roots[w.ri] = w.b;
      OP_READ_ROOT: if (w.ri < NROOT) r.obj = roots[w.ri];
      default: gc(xa, xb, 0);
    endcase
    r.used = HC_W'(alloc_pt);
    return r;
  endfunction

  // keep pair pointers away from cells that were never written
  function automatic logic [31:0] safe_obj(logic [31:0] obj);
    if (obj[31:29] == TAG_PAIR && obj[28:0] < NCELL && int'(obj[28:0]) >= alloc_pt)
      obj[10] = 1'b1;
    return obj;
  endfunction

  function automatic logic [31:0] live_pair();
    if (alloc_pt == 0) return NULL_WORD;
    return {3'b0, 29'($urandom_range(0, alloc_pt - 1))};
  endfunction

  function automatic logic [31:0] pick_obj();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return live_pair();
      4: return {3'b0, 29'($urandom) | 29'h400};
      5: return NULL_WORD;
      6: return {3'($urandom_range(2, 3)), 29'($urandom)};
      7: return safe_obj($urandom);
      8: return {3'(TAG_HEART), 29'($urandom)};
      default: return safe_obj($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h1FFF_FFFF);
    endcase
  endfunction

  task automatic issue(op_t op, logic [31:0] a, logic [31:0] b, logic [2:0] ri);
    heap_op_t w;
    w.op = op;
    w.a = a;
    w.b = b;
    w.ri = ri;
    awaited.push_back(apply_op(w));
    pending_ops.push_back(w);
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || item_valid || awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limit(logic [HC_W-1:0] v);
    drain();
    @(posedge clk);
    heap_cells_we <= 1;
    heap_cells_data <= v;
    @(posedge clk);
    heap_cells_we <= 0;
    limit_reg = v;
  endtask

  task automatic wipe_heap();
    for (int i = 0; i < NROOT; i++) issue(OP_WRITE_ROOT, '0, NULL_WORD, 3'(i));
    issue(OP_COLLECT, '0, '0, '0);
  endtask

  task automatic random_ops(int n, int gc_pct);
    int k;
    op_t op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < gc_pct) op = OP_COLLECT;
      else if (k < 35) op = OP_CONS;
      else if (k < 47) op = OP_CAR;
      else if (k < 57) op = OP_CDR;
      else if (k < 65) op = OP_SET_CAR;
      else if (k < 73) op = OP_SET_CDR;
      else if (k < 88) op = OP_WRITE_ROOT;
      else op = OP_READ_ROOT;
      issue(op, pick_obj(), pick_obj(), 3'($urandom_range(0, 7)));
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH word %0d %s: got %h want %h", n_words, what, got, want);
  endtask

  // driver
  int tx_gap = 0;
  always @(posedge clk) begin
    heap_op_t w;
    if (rst) begin
      item_valid <= 0;
    end else if (!item_valid || item_ready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        item_valid <= 0;
      end else if (pending_ops.size() != 0) begin
        w = pending_ops.pop_front();
        opcode <= w.op;
        object_a <= w.a;
        object_b <= w.b;
        root_index <= w.ri;
        item_valid <= 1;
        tx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 5) : 0;
      end else begin
        item_valid <= 0;
      end
    end
  end

  // receiver and checker
  int rx_stall = 0;
  always @(posedge clk) begin
    heap_res_t e;
    if (rst) begin
      result_ready <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (awaited.size() == 0) begin
          report("unexpected word", result_object, '0);
        end else begin
          e = awaited.pop_front();
          if (result_object !== e.obj) report("result_object", result_object, e.obj);
          if (status !== e.st) report("status", 32'(status), 32'(e.st));
          if (cells_in_use !== e.used) report("cells_in_use", 32'(cells_in_use), 32'(e.used));
        end
        n_words++;
        rx_stall = $urandom_range(0, 3) == 0 ? $urandom_range(0, 5) : 0;
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      result_ready <= !hold_rx && rx_stall == 0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    wait (!rst && n_words > 300);
    @(posedge clk);
    hold_rx <= 1;
    repeat (400) @(posedge clk);
    hold_rx <= 0;
  end

  initial begin
    half = 0;
    alloc_pt = 0;
    scan_pt = 0;
    limit_reg = HC_RESET;
    foreach (moved[i]) moved[i] = 0;
    foreach (roots[i]) roots[i] = NULL_WORD;
    repeat (5) @(posedge clk);
    rst <= 0;

    issue(OP_CONS, 32'h0000_0000, 32'hFFFF_FFFF, '0);
    issue(OP_CONS, 32'h2000_0000, 32'h0000_0000, '0);
    issue(OP_CAR, 32'h0000_0001, '0, '0);
    issue(OP_CDR, 32'h0000_0000, '0, '0);
    issue(OP_CAR, 32'h6000_0005, '0, '0);
    issue(OP_CDR, 32'h0000_0400, '0, '0);
    issue(OP_SET_CAR, 32'h0000_0001, 32'hFFFF_FFFF, '0);
    issue(OP_SET_CDR, 32'h0000_0001, 32'h0000_0000, '0);
    issue(OP_SET_CAR, 32'h1FFF_FFFF, 32'h1234_5678, '0);
    issue(OP_SET_CDR, NULL_WORD, '0, '0);
    issue(OP_WRITE_ROOT, '0, 32'h0000_0001, 3'd0);
    issue(OP_WRITE_ROOT, '0, 32'hFFFF_FFFF, 3'd6);
    issue(OP_WRITE_ROOT, '0, 32'h0000_0000, 3'd7);
    issue(OP_READ_ROOT, '0, '0, 3'd7);
    issue(OP_COLLECT, '0, '0, '0);
    issue(OP_READ_ROOT, '0, '0, 3'd0);
    issue(OP_CAR, live_pair(), '0, '0);
    issue(OP_READ_ROOT, '0, '0, 3'd6);
    issue(OP_COLLECT, '0, '0, '0);
    random_ops(500, 3);

    set_limit(11'd64);
    random_ops(150, 2);
    set_limit(11'd8);
    random_ops(120, 4);
    set_limit(11'd1);
    random_ops(60, 5);
    set_limit(11'd0);
    issue(OP_CONS, NULL_WORD, NULL_WORD, '0);
    issue(OP_WRITE_ROOT, '0, live_pair(), 3'd2);
    issue(OP_CONS, live_pair(), NULL_WORD, '0);
    random_ops(40, 5);

    wipe_heap();
    set_limit(11'h7FF);
    random_ops(250, 2);
    wipe_heap();
    set_limit(11'd16);
    random_ops(120, 4);

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d words: %0d collections, %0d out of memory, %0d non-pair accesses",
             n_words, n_gc, n_oom, n_bad);
    $display("heap limits 1024, 64, 8, 1, 0, 2047 and 16 with idling and a long output hold");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
